>>> sv/ccfd_pkg.sv
// ----------------------------------------------------------------------------
// ccfd_pkg
// Shared constants, state type and CRC step for the COBS/CRC frame decoder.
// ----------------------------------------------------------------------------
package ccfd_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int MAX_WIRE    = 64;
	localparam int HDR_LEN     = 18;
	localparam int OVERHEAD    = 22;
	localparam int RAW_CAP     = OVERHEAD + MAX_PAYLOAD;

	localparam int RX_AW   = $clog2(MAX_WIRE);
	localparam int FILL_W  = $clog2(MAX_WIRE + 1);
	localparam int DEC_AW  = $clog2(RAW_CAP);
	localparam int WCNT_W  = $clog2(RAW_CAP + 1);
	localparam int HDR_AW  = $clog2(HDR_LEN);
	localparam int KCNT_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int PLEN_W  = 6;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [7:0]  COBS_MAX_CODE = 8'd255;
	localparam logic [7:0]  HDR_VERSION   = 8'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC_START,
		ST_DEC_RD,
		ST_DEC_USE,
		ST_BLK_END,
		ST_CHECK,
		ST_REJECT,
		ST_FAIL,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} ccfd_state_t;

	// one byte of reflected CRC-32
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

>>> sv/ccfd_ram.sv
// ----------------------------------------------------------------------------
// ccfd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccfd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/cobs_crc_frame_decoder.sv
// ----------------------------------------------------------------------------
// cobs_crc_frame_decoder
// COBS frame decoder with header checks and CRC-32 trailer check.
// ----------------------------------------------------------------------------
// Order: a nonzero byte is stored as it is accepted. A delimiter runs a start
//   state, a read and a use state per wire byte, a block end per COBS block,
//   a check, then read and output states per item; a reject passes REJECT, FAIL.
// Throughput: input ready only in idle; stalls from a delimiter to its last item.
// Reset: arst_n clears fill count, discard flag, error counter, FSM and
//   max_channel (to 255). Memories are not cleared; no clearing pass.
module cobs_crc_frame_decoder
	import ccfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] wire_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // channel, msg_type, epoch, session,
	                                // sequence_res, payload_length[5:0],
	                                // payload_byte, error_count, 2'b0 pad
	output logic [1:0]   m_tuser,   // [0] frame_ok, [1] payload_valid
	output logic         m_tlast,   // last
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata  // max_channel
);

	ccfd_state_t state_q, state_d;

	// wire side
	logic [FILL_W-1:0] fill_q, n_q, r_q;
	logic              discard_q, disc_s_q, count_q;
	logic [7:0]        max_channel_q;
	logic [31:0]       err_q;

	// decode walk
	logic [7:0]        code_q, rem_q;
	logic [WCNT_W-1:0] w_q;
	logic [31:0]       crc_q;
	logic [7:0]        dl_q [4];       // last four decoded bytes, [0] newest
	logic [7:0]        hdr_q [HDR_LEN];
	logic [PLEN_W-1:0] plen_q;
	logic [KCNT_W-1:0] k_q;

	// memories
	logic [7:0] rx_rd, dec_rd;
	logic       push_en;
	logic [7:0] push_byte;
	logic [DEC_AW-1:0] dec_raddr;

	// output register
	logic        out_free, out_load;
	logic        m_tvalid_q;

	wire in_fire = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	ccfd_ram #(.DEPTH(MAX_WIRE), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (in_fire && (s_tdata != 8'd0) && !discard_q && (fill_q < FILL_W'(MAX_WIRE))),
		.waddr (fill_q[RX_AW-1:0]),
		.wdata (s_tdata),
		.raddr (r_q[RX_AW-1:0]),
		.rdata (rx_rd)
	);

	assign dec_raddr = DEC_AW'(HDR_LEN) + DEC_AW'(k_q);

	ccfd_ram #(.DEPTH(RAW_CAP), .WIDTH(8)) u_dec_ram (
		.clk   (clk),
		.we    (push_en),
		.waddr (w_q[DEC_AW-1:0]),
		.wdata (push_byte),
		.raddr (dec_raddr),
		.rdata (dec_rd)
	);

	// frame checks
	logic [15:0] len16;
	logic [31:0] trailer;
	logic        w_full, code_bad, frame_good, emit_last;
	logic [KCNT_W-1:0] emit_cnt;

	assign len16   = {hdr_q[17], hdr_q[16]};
	assign trailer = {dl_q[0], dl_q[1], dl_q[2], dl_q[3]};
	assign w_full  = (w_q >= WCNT_W'(RAW_CAP));
	// r_q already points past the code byte
	assign code_bad = (rx_rd == 8'd0) ||
		(({1'b0, rx_rd} - 9'd1) > 9'(n_q - r_q));
	assign frame_good = (w_q >= WCNT_W'(OVERHEAD)) && (hdr_q[0] == HDR_VERSION) &&
		(hdr_q[1] <= max_channel_q) && (hdr_q[3] == 8'd0) &&
		(len16 <= 16'(MAX_PAYLOAD)) && (17'(w_q) == 17'(len16) + 17'(OVERHEAD)) &&
		(trailer == ~crc_q);
	assign emit_cnt  = (plen_q == '0) ? KCNT_W'(1) : KCNT_W'(plen_q);
	assign emit_last = (k_q + KCNT_W'(1) == emit_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		push_en   = 1'b0;
		push_byte = 8'd0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && s_tdata == 8'd0) state_d = ST_DEC_START;
			end
			ST_DEC_START: begin
				if (disc_s_q || n_q == '0 || n_q >= FILL_W'(MAX_WIRE)) state_d = ST_REJECT;
				else state_d = ST_DEC_RD;
			end
			ST_DEC_RD: begin
				state_d = (r_q == n_q) ? ST_CHECK : ST_DEC_USE;
			end
			ST_DEC_USE: begin
				if (rem_q == 8'd0) begin
					if (code_bad) state_d = ST_REJECT;
					else if (rx_rd == 8'd1) state_d = ST_BLK_END;
					else state_d = ST_DEC_RD;
				end else if (w_full) begin
					state_d = ST_REJECT;
				end else begin
					push_en   = 1'b1;
					push_byte = rx_rd;
					state_d   = (rem_q == 8'd1) ? ST_BLK_END : ST_DEC_RD;
				end
			end
			ST_BLK_END: begin
				// implicit zero unless a full-length block or end of data
				if (code_q != COBS_MAX_CODE && r_q < n_q) begin
					if (w_full) begin
						state_d = ST_REJECT;
					end else begin
						push_en = 1'b1;
						state_d = ST_DEC_RD;
					end
				end else begin
					state_d = ST_DEC_RD;
				end
			end
			ST_CHECK:  state_d = frame_good ? ST_EMIT_RD : ST_REJECT;
			ST_REJECT: state_d = ST_FAIL;
			ST_FAIL: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EMIT_RD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			discard_q     <= 1'b0;
			err_q         <= '0;
			max_channel_q <= 8'd255;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) max_channel_q <= cfg_wdata;
			if (in_fire) begin
				if (s_tdata == 8'd0) begin
					fill_q    <= '0;
					discard_q <= 1'b0;
				end else if (!discard_q) begin
					if (fill_q >= FILL_W'(MAX_WIRE)) begin
						discard_q <= 1'b1;
						fill_q    <= '0;
					end else begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end
			end
			if (state_q == ST_REJECT && count_q) err_q <= err_q + 32'd1;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire && s_tdata == 8'd0) begin
			n_q      <= fill_q;
			disc_s_q <= discard_q;
		end
		if (state_q == ST_DEC_START) begin
			r_q     <= '0;
			w_q     <= '0;
			rem_q   <= 8'd0;
			crc_q   <= CRC_INIT;
			count_q <= disc_s_q || (n_q != '0);
		end
		if (state_q == ST_DEC_RD && r_q != n_q) r_q <= r_q + FILL_W'(1);
		if (state_q == ST_DEC_USE) begin
			if (rem_q == 8'd0) begin
				code_q <= rx_rd;
				rem_q  <= rx_rd - 8'd1;
			end else begin
				rem_q <= rem_q - 8'd1;
			end
		end
		if (push_en) begin
			if (w_q < WCNT_W'(HDR_LEN)) hdr_q[w_q[HDR_AW-1:0]] <= push_byte;
			// CRC covers everything but the trailing four bytes
			if (w_q >= WCNT_W'(4)) crc_q <= crc_byte(crc_q, dl_q[3]);
			dl_q[0] <= push_byte;
			dl_q[1] <= dl_q[0];
			dl_q[2] <= dl_q[1];
			dl_q[3] <= dl_q[2];
			w_q     <= w_q + WCNT_W'(1);
		end
		if (state_q == ST_CHECK) begin
			plen_q <= len16[PLEN_W-1:0];
			k_q    <= '0;
		end
		if (state_q == ST_EMIT_OUT && out_load) k_q <= k_q + KCNT_W'(1);
		if (out_load) begin
			if (state_q == ST_FAIL) begin
				m_tdata <= {2'b00, err_q, 126'd0};
				m_tuser <= 2'b00;
			end else begin
				m_tdata <= {2'b00, err_q,
					(plen_q == '0) ? 8'd0 : dec_rd, plen_q,
					hdr_q[15], hdr_q[14], hdr_q[13], hdr_q[12],
					hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8],
					hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4],
					hdr_q[2], hdr_q[1]};
				m_tuser <= {(plen_q != '0), 1'b1};
			end
			m_tlast <= (state_q == ST_FAIL) || emit_last;
		end
	end

endmodule

>>> sv/ccfd_checker.sv
// ----------------------------------------------------------------------------
// ccfd_checker
// Port-level assertions for the COBS/CRC frame decoder.
// ----------------------------------------------------------------------------
module ccfd_checker
	import ccfd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1])
		else $error("failure item not single");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[125:0] == 126'd0)
		else $error("failure item carries header data");

	a_empty_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tlast && m_tdata[117:112] == 6'd0)
		else $error("empty good frame malformed");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |->
			m_tdata[117:112] != 6'd0 && m_tdata[117:112] <= PLEN_W'(MAX_PAYLOAD))
		else $error("payload length out of range");

endmodule

bind cobs_crc_frame_decoder ccfd_checker u_ccfd_checker (.*);
